[sv/pdvm_pkg.sv]
// shared types and constants for the perspective divide and viewport map
`default_nettype none
package pdvm_pkg;
    localparam int QW = 31;
    localparam int RW = 33;
    localparam int LANES = 3;
    localparam logic [7:0] REG_WIDTH = 8'd0;
    localparam logic [7:0] REG_HEIGHT = 8'd1;
    localparam logic [15:0] WIDTH_RESET = 16'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] dvd;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
    } pdvm_lane_t;

    typedef struct packed {
        logic                   valid;
        logic                   inv;
        logic [RW-1:0]          d;
        pdvm_lane_t [LANES-1:0] lane;
    } pdvm_word_t;
endpackage
`default_nettype wire

[sv/pdvm_cell.sv]
// one restoring divide cell: one quotient bit per lane
`default_nettype none
module pdvm_cell
    import pdvm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire pdvm_word_t word_in,
    output pdvm_word_t      word_out
);
    pdvm_word_t word_next;
    pdvm_word_t word_reg;
    logic [RW:0] trial [LANES];
    logic        ge [LANES];

    always_comb
    begin
        word_next = word_in;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {word_in.lane[i].rem, word_in.lane[i].dvd[QW-1]};
            ge[i] = trial[i] >= {1'b0, word_in.d};
            word_next.lane[i].rem = ge[i] ? RW'(trial[i] - {1'b0, word_in.d})
                                          : trial[i][RW-1:0];
            word_next.lane[i].dvd = {word_in.lane[i].dvd[QW-2:0], 1'b0};
            word_next.lane[i].quo = {word_in.lane[i].quo[QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;
endmodule
`default_nettype wire

[sv/perspective_divide_viewport_map.sv]
// top level: perspective divide and viewport map of one clip-space vertex
// in channel: in_valid/in_stall with clip_x, clip_y, clip_z, clip_w (q16.16)
// out channel: out_valid/out_stall with screen_x, screen_y, depth and flags
// config channel: cfg_valid/cfg_ready, cfg_index 0 width, 1 height; ready
//   is always high, other indexes are ignored
// throughput: one vertex per cycle sustained while the receiver does not stall
// pipeline: input, multiply and setup stages, then the row of 31 divide
//   cells (one quotient bit each), then the output register
// the three coordinates share one divisor and run as lanes in every cell
// when the receiver stalls with a word waiting, the whole row holds and
//   in_stall rises in the same cycle; nothing is dropped
// reset clears all valid bits and loads width 640 and height 480
`default_nettype none
module perspective_divide_viewport_map
    import pdvm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] clip_x,
    input  wire logic [31:0] clip_y,
    input  wire logic [31:0] clip_z,
    input  wire logic [31:0] clip_w,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      screen_x,
    output logic [31:0]      screen_y,
    output logic [31:0]      depth,
    output logic             w_invalid,
    output logic             saturated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic        en;
    logic [15:0] wid_reg;
    logic [15:0] hei_reg;

    logic        a_valid_reg;
    logic [31:0] ax_reg, ay_reg, az_reg, aw_reg;
    logic        b_valid_reg;
    logic signed [49:0] bx_reg, by_reg, bx_next, by_next;
    logic [31:0] bz_reg, bw_reg;

    logic signed [32:0] sx, sy;
    logic signed [65:0] n [LANES];
    logic [64:0]        m [LANES];
    logic [32:0]        dd;
    pdvm_word_t         c_next;
    pdvm_word_t         chain [QW+1];

    logic        out_valid_reg;
    logic [31:0] q [LANES];
    logic [31:0] res_next [LANES];
    logic [31:0] sx_reg, sy_reg, dz_reg;
    logic        inv_reg, sat_reg, sat_next;

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg <= WIDTH_RESET;
            hei_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                wid_reg <= cfg_data;
            end
            else if (cfg_index == REG_HEIGHT)
            begin
                hei_reg <= cfg_data;
            end
        end
    end

    // input and multiply stages
    assign sx = $signed({aw_reg[31], aw_reg});
    always_comb
    begin
        sy = $signed({aw_reg[31], aw_reg}) - $signed({ay_reg[31], ay_reg});
        bx_next = 50'(($signed({ax_reg[31], ax_reg}) + sx) * $signed({1'b0, wid_reg}));
        by_next = 50'(sy * $signed({1'b0, hei_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= clip_x;
            ay_reg <= clip_y;
            az_reg <= clip_z;
            aw_reg <= clip_w;
            bx_reg <= bx_next;
            by_reg <= by_next;
            bz_reg <= az_reg;
            bw_reg <= aw_reg;
        end
    end

    // setup: floor((2n + w) / 2w) on a non-negative dividend
    always_comb
    begin
        dd = {bw_reg, 1'b0};
        n[0] = $signed({bx_reg, 16'b0}) + $signed({{34{bw_reg[31]}}, bw_reg});
        n[1] = $signed({by_reg, 16'b0}) + $signed({{34{bw_reg[31]}}, bw_reg});
        n[2] = $signed({{17{bz_reg[31]}}, bz_reg, 17'b0})
             + $signed({{34{bw_reg[31]}}, bw_reg});
        c_next.valid = b_valid_reg;
        c_next.inv = bw_reg[31] || (bw_reg == 32'd0);
        c_next.d = dd;
        for (int i = 0; i < LANES; i++)
        begin
            m[i] = n[i][65] ? ~n[i][64:0] : n[i][64:0];
            c_next.lane[i].neg = n[i][65];
            c_next.lane[i].ovf = m[i][64:31] >= {1'b0, dd};
            c_next.lane[i].rem = m[i][63:31];
            c_next.lane[i].dvd = m[i][30:0];
            c_next.lane[i].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain[0] <= '0;
        end
        else if (en)
        begin
            chain[0] <= c_next;
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_cell
        pdvm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .word_in  (chain[g]),
            .word_out (chain[g+1])
        );
    end

    // sign restore, clamp, zero on invalid w and output register
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            q[i] = chain[QW].lane[i].neg ? ~{1'b0, chain[QW].lane[i].quo}
                                         : {1'b0, chain[QW].lane[i].quo};
            if (chain[QW].inv)
            begin
                res_next[i] = '0;
            end
            else if (chain[QW].lane[i].ovf)
            begin
                res_next[i] = chain[QW].lane[i].neg ? 32'h8000_0000 : 32'h7fff_ffff;
                sat_next = 1'b1;
            end
            else
            begin
                res_next[i] = q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= res_next[0];
            sy_reg  <= res_next[1];
            dz_reg  <= res_next[2];
            inv_reg <= chain[QW].inv;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign depth     = dz_reg;
    assign w_invalid = inv_reg;
    assign saturated = sat_reg;

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && w_invalid) |-> (screen_x == 32'd0 && screen_y == 32'd0
                                      && depth == 32'd0 && !saturated))
        else $error("invalid w with nonzero result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(screen_x) && $stable(depth)))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");
endmodule
`default_nettype wire
